// File: src/mfv_pkg.sv
`timescale 1ns / 1ps

package mfv_pkg;

  // Slot geometry
  localparam int SLOT_BYTES   = 512;
  localparam int HEADER_BYTES = 20;
  localparam int MAX_PAYLOAD  = SLOT_BYTES - HEADER_BYTES;

  // Byte count saturates one past the longest payload end
  localparam int POS_LIMIT = HEADER_BYTES + 65536;
  localparam int POS_W     = $clog2(POS_LIMIT + 1);

  // Header field offsets (little-endian)
  localparam int OFS_VERSION  = 4;
  localparam int OFS_LENGTH   = 6;
  localparam int OFS_SEQUENCE = 8;
  localparam int OFS_COMMAND  = 12;
  localparam int OFS_RESERVED = 14;
  localparam int OFS_CHECKSUM = 16;

  // Reflected CRC-32
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Configuration register indexes
  localparam logic REG_MAGIC_WORD     = 1'b0;
  localparam logic REG_FORMAT_VERSION = 1'b1;

  typedef enum logic [1:0] {
    ST_ABSENT  = 2'd0,
    ST_CORRUPT = 2'd1,
    ST_VALID   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_start;
    logic        frame_end;
    logic [31:0] previous_sequence;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] command_code;
    logic [31:0] message_sequence;
    logic [8:0]  payload_bytes;
  } result_t;

  // One byte through the reflected CRC-32, LSB first
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: src/mfv_frame_check.sv
`timescale 1ns / 1ps

module mfv_frame_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mfv_pkg::item_t   item,
  input  logic [31:0]      magic_word,
  input  logic [15:0]      format_version,
  output logic             push,
  output mfv_pkg::result_t result
);
  import mfv_pkg::*;

  // Frame state
  logic [POS_W-1:0] pos;
  logic [31:0]      magic;
  logic [15:0]      version;
  logic [15:0]      length;
  logic [31:0]      sequence_id;
  logic [15:0]      command;
  logic [31:0]      checksum;
  logic [31:0]      crc;
  logic [31:0]      saved_prev;
  logic             active;

  // Values after a possible frame restart
  logic [POS_W-1:0] pos_e;
  logic [15:0]      length_e;
  logic [31:0]      crc_e;
  logic             active_e;

  logic [POS_W-1:0] pos_next;
  logic [31:0]      magic_next;
  logic [15:0]      version_next;
  logic [15:0]      length_next;
  logic [31:0]      sequence_id_next;
  logic [15:0]      command_next;
  logic [31:0]      checksum_next;
  logic [31:0]      crc_next;
  logic [31:0]      saved_prev_next;
  logic             active_next;

  logic [POS_W-1:0] payload_ofs;
  logic [POS_W-1:0] need_pos;
  logic             absent;
  logic             corrupt;

  always_comb begin
    pos_e    = item.frame_start ? '0 : pos;
    length_e = item.frame_start ? '0 : length;
    crc_e    = item.frame_start ? CRC_INIT : crc;
    active_e = item.frame_start | active;

    magic_next       = item.frame_start ? '0 : magic;
    version_next     = item.frame_start ? '0 : version;
    length_next      = length_e;
    sequence_id_next = item.frame_start ? '0 : sequence_id;
    command_next     = item.frame_start ? '0 : command;
    checksum_next    = item.frame_start ? '0 : checksum;
    crc_next         = crc_e;
    saved_prev_next  = item.frame_start ? item.previous_sequence : saved_prev;
    payload_ofs      = pos_e - POS_W'(HEADER_BYTES);

    // Header capture or payload CRC
    if (pos_e < POS_W'(OFS_VERSION)) begin
      magic_next[{pos_e[1:0], 3'b000} +: 8] = item.data_byte;
    end else if (pos_e < POS_W'(OFS_LENGTH)) begin
      version_next[{pos_e[0], 3'b000} +: 8] = item.data_byte;
    end else if (pos_e < POS_W'(OFS_SEQUENCE)) begin
      length_next[{pos_e[0], 3'b000} +: 8] = item.data_byte;
    end else if (pos_e < POS_W'(OFS_COMMAND)) begin
      sequence_id_next[{pos_e[1:0], 3'b000} +: 8] = item.data_byte;
    end else if (pos_e < POS_W'(OFS_RESERVED)) begin
      command_next[{pos_e[0], 3'b000} +: 8] = item.data_byte;
    end else if (pos_e < POS_W'(OFS_CHECKSUM)) begin
      // reserved half-word, dropped
    end else if (pos_e < POS_W'(HEADER_BYTES)) begin
      checksum_next[{pos_e[1:0], 3'b000} +: 8] = item.data_byte;
    end else if (payload_ofs < POS_W'(length_e)) begin
      crc_next = crc32_byte(crc_e, item.data_byte);
    end

    pos_next    = (pos_e < POS_W'(POS_LIMIT)) ? pos_e + POS_W'(1) : pos_e;
    active_next = active_e & ~item.frame_end;

    // End-of-slot verdict on the updated state
    need_pos = POS_W'(length_next) + POS_W'(HEADER_BYTES);
    absent   = (magic_next != magic_word) || (version_next != format_version) ||
               (sequence_id_next == saved_prev_next);
    corrupt  = (length_next > 16'(MAX_PAYLOAD)) || (pos_next < need_pos) ||
               (~crc_next != checksum_next);

    result = '0;
    if (absent) begin
      result.status = ST_ABSENT;
    end else if (corrupt) begin
      result.status = ST_CORRUPT;
    end else begin
      result.status           = ST_VALID;
      result.command_code     = command_next;
      result.message_sequence = sequence_id_next;
      result.payload_bytes    = length_next[8:0];
    end

    push = step & active_e & item.frame_end;
  end

  // State update; bytes outside a frame leave it untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      magic       <= '0;
      version     <= '0;
      length      <= '0;
      sequence_id <= '0;
      command     <= '0;
      checksum    <= '0;
      crc         <= CRC_INIT;
      saved_prev  <= '0;
      active      <= 1'b0;
    end else if (step && active_e) begin
      pos         <= pos_next;
      magic       <= magic_next;
      version     <= version_next;
      length      <= length_next;
      sequence_id <= sequence_id_next;
      command     <= command_next;
      checksum    <= checksum_next;
      crc         <= crc_next;
      saved_prev  <= saved_prev_next;
      active      <= active_next;
    end
  end

endmodule

// File: src/mfv_result_queue.sv
`timescale 1ns / 1ps

module mfv_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mfv_pkg::result_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output mfv_pkg::result_t head
);
  import mfv_pkg::*;

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  // Two-entry output buffer: input side keeps moving while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: src/mailbox_frame_validator.sv
`timescale 1ns / 1ps
// An accepted byte is registered in the input register and checked from there; a slot's result
//   is queued in the result buffer and offered on out_valid. Throughput: one byte per cycle while
//   the result buffer has room, set by the byte-wide CRC-32 step and header capture.
// Reset (rst, synchronous, active high) clears the frame state, presets the CRC to
//   all ones, zeroes both configuration registers and empties the item buffers.

module mailbox_frame_validator (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic        frame_end,
  input  logic [31:0] previous_sequence,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] command_code,
  output logic [31:0] message_sequence,
  output logic [8:0]  payload_bytes
);
  import mfv_pkg::*;

  logic [31:0] magic_word;
  logic [15:0] format_version;

  item_t   in_q;
  logic    in_q_valid;
  logic    take;
  logic    step;
  logic    q_full;
  logic    push;
  result_t result;
  result_t head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word     <= '0;
      format_version <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_MAGIC_WORD:     magic_word     <= cfg_data;
        REG_FORMAT_VERSION: format_version <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register; it drains whenever the result buffer has room
  assign step     = in_q_valid & ~q_full;
  assign in_stall = in_q_valid & q_full;
  assign take     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= take | (in_q_valid & ~step);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q.data_byte         <= data_byte;
      in_q.frame_start       <= frame_start;
      in_q.frame_end         <= frame_end;
      in_q.previous_sequence <= previous_sequence;
    end
  end

  mfv_frame_check u_check (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .item           (in_q),
    .magic_word     (magic_word),
    .format_version (format_version),
    .push           (push),
    .result         (result)
  );

  mfv_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (~out_stall),
    .full      (q_full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign status           = head.status;
  assign command_code     = head.command_code;
  assign message_sequence = head.message_sequence;
  assign payload_bytes    = head.payload_bytes;

endmodule

// File: src/mfv_checker.sv
`timescale 1ns / 1ps

module mfv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [15:0] command_code,
  input logic [31:0] message_sequence,
  input logic [8:0]  payload_bytes
);
  import mfv_pkg::*;

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(command_code) &&
      $stable(message_sequence) && $stable(payload_bytes))
    else $error("stalled result changed");

  // Header fields are reported only for a valid message
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_VALID |->
      command_code == '0 && message_sequence == '0 && payload_bytes == '0)
    else $error("fields reported for a message that is not valid");

  // A valid message's payload fits in the slot
  a_len_fits: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_VALID |-> payload_bytes <= 9'(MAX_PAYLOAD))
    else $error("valid message longer than the slot");

endmodule

bind mailbox_frame_validator mfv_checker u_mfv_checker (.*);

// File: sim/mailbox_frame_validator_chk.sv
`timescale 1ns / 1ps

// Watches both channels of the validator, predicts each slot outcome and
// compares it with what the block reports.
module mailbox_frame_validator_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_en,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic        frame_end,
  input  logic [31:0] previous_sequence,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [15:0] command_code,
  input  logic [31:0] message_sequence,
  input  logic [8:0]  payload_bytes,
  output int          mismatches,
  output int          outcomes_owed
);
  import mfv_pkg::*;

  // Shadow of the configuration registers
  logic [31:0] want_magic;
  logic [15:0] want_version;

  // Shadow of the slot parser
  int unsigned pos;
  logic [31:0] hdr_magic;
  logic [15:0] hdr_version;
  logic [15:0] hdr_length;
  logic [31:0] hdr_sequence;
  logic [15:0] hdr_command;
  logic [31:0] hdr_crc;
  logic [31:0] crc_acc;
  logic [31:0] prev_seq;
  bit          in_frame;

  // Outcomes predicted but not yet reported, oldest first
  result_t outcome_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  // Advance the parser by one accepted item; queue an outcome on slot end
  task automatic take_byte(input logic [7:0] b, input logic s, input logic e,
                           input logic [31:0] prev);
    result_t r;
    if (s) begin
      pos          = 0;
      hdr_magic    = '0;
      hdr_version  = '0;
      hdr_length   = '0;
      hdr_sequence = '0;
      hdr_command  = '0;
      hdr_crc      = '0;
      crc_acc      = CRC_INIT;
      prev_seq     = prev;
      in_frame     = 1'b1;
    end
    // bytes outside a slot are dropped
    if (!in_frame) return;

    if (pos < HEADER_BYTES) begin
      if (pos < OFS_VERSION) hdr_magic[8*pos +: 8] = b;
      else if (pos < OFS_LENGTH) hdr_version[8*(pos-OFS_VERSION) +: 8] = b;
      else if (pos < OFS_SEQUENCE) hdr_length[8*(pos-OFS_LENGTH) +: 8] = b;
      else if (pos < OFS_COMMAND) hdr_sequence[8*(pos-OFS_SEQUENCE) +: 8] = b;
      else if (pos < OFS_RESERVED) hdr_command[8*(pos-OFS_COMMAND) +: 8] = b;
      else if (pos >= OFS_CHECKSUM) hdr_crc[8*(pos-OFS_CHECKSUM) +: 8] = b;
    end else if (pos - HEADER_BYTES < hdr_length) begin
      crc_acc = crc_step(crc_acc, b);
    end
    if (pos < POS_LIMIT) pos++;

    if (!e) return;
    in_frame = 1'b0;

    r = '0;
    if (hdr_magic != want_magic || hdr_version != want_version ||
        hdr_sequence == prev_seq) begin
      r.status = ST_ABSENT;
    end else if (hdr_length > MAX_PAYLOAD || pos < HEADER_BYTES + hdr_length ||
                 ~crc_acc != hdr_crc) begin
      r.status = ST_CORRUPT;
    end else begin
      r.status           = ST_VALID;
      r.command_code     = hdr_command;
      r.message_sequence = hdr_sequence;
      r.payload_bytes    = hdr_length[8:0];
    end
    outcome_q.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    result_t w;
    if (rst) begin
      want_magic   = '0;
      want_version = '0;
      prev_seq     = '0;
      in_frame     = 1'b0;
      pos          = 0;
      hdr_magic    = '0;
      hdr_version  = '0;
      hdr_length   = '0;
      hdr_sequence = '0;
      hdr_command  = '0;
      hdr_crc      = '0;
      crc_acc      = CRC_INIT;
      mismatches   = 0;
      outcome_q.delete();
    end else begin
      // register writes
      if (cfg_en) begin
        if (cfg_index == REG_MAGIC_WORD) want_magic = cfg_data;
        else want_version = cfg_data[15:0];
      end
      // reported outcome against the oldest prediction
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("outcome with none owed, status", 32'(status), '0);
        end else begin
          w = outcome_q.pop_front();
          if (status !== w.status)
            report_mismatch("status", 32'(status), 32'(w.status));
          if (command_code !== w.command_code)
            report_mismatch("command_code", 32'(command_code), 32'(w.command_code));
          if (message_sequence !== w.message_sequence)
            report_mismatch("message_sequence", message_sequence, w.message_sequence);
          if (payload_bytes !== w.payload_bytes)
            report_mismatch("payload_bytes", 32'(payload_bytes), 32'(w.payload_bytes));
        end
      end
      // accepted slot byte
      if (in_valid && !in_stall)
        take_byte(data_byte, frame_start, frame_end, previous_sequence);
    end
    outcomes_owed = outcome_q.size();
  end

endmodule

// File: sim/mailbox_frame_validator_tb.sv
`timescale 1ns / 1ps

module mailbox_frame_validator_tb;
  import mfv_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 220;

  typedef struct {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [31:0] prev;
  } slot_byte_t;

  logic        clk;
  logic        rst;
  logic        cfg_en;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic        frame_end;
  logic [31:0] previous_sequence;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] command_code;
  logic [31:0] message_sequence;
  logic [8:0]  payload_bytes;
  int          mismatches;
  int          outcomes_owed;

  slot_byte_t  slot_q[$];
  logic [31:0] cur_magic;
  logic [15:0] cur_version;
  bit          idle_on = 1'b1;
  bit          want_hold = 1'b0;
  int          phase_items;

  mailbox_frame_validator dut (.*);
  mailbox_frame_validator_chk chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    forever begin
      if (want_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        want_hold = 1'b0;
      end
      out_stall <= idle_on && ($urandom_range(99) < 31);
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic s, input logic e);
    slot_q.push_back('{data: b, first: s, last: e, prev: $urandom});
  endtask

  // Flag the slot's first and last byte
  task automatic mark_slot(input logic [31:0] prev);
    slot_q[0].first = 1'b1;
    slot_q[0].prev  = prev;
    slot_q[slot_q.size()-1].last = 1'b1;
  endtask

  // Header plus sent_pay payload bytes; CRC covers the first len of them
  task automatic add_message(input logic [31:0] magic, input logic [15:0] version,
                             input logic [15:0] len, input logic [31:0] seq,
                             input int unsigned sent_pay, input bit bad_crc);
    logic [7:0]   pay[$];
    logic [31:0]  crc;
    logic [159:0] hdr;
    logic [15:0]  cmd;
    logic [15:0]  rsv;
    crc = CRC_INIT;
    for (int i = 0; i < sent_pay; i++) begin
      pay.push_back(8'($urandom));
      if (i < len) crc = crc32_byte(crc, pay[i]);
    end
    crc = ~crc;
    if (bad_crc) crc[$urandom_range(31)] ^= 1'b1;
    cmd = 16'($urandom);
    rsv = 16'($urandom);
    hdr = {crc, rsv, cmd, seq, len, version, magic};
    for (int k = 0; k < HEADER_BYTES; k++) push_byte(hdr[8*k +: 8], 1'b0, 1'b0);
    foreach (pay[i]) push_byte(pay[i], 1'b0, 1'b0);
  endtask

  // Offer the built slot one item at a time, with random gaps while idling is on
  task automatic send_slot();
    foreach (slot_q[i]) begin
      while (idle_on && $urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid          <= 1'b1;
      data_byte         <= slot_q[i].data;
      frame_start       <= slot_q[i].first;
      frame_end         <= slot_q[i].last;
      previous_sequence <= slot_q[i].prev;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    slot_q.delete();
  endtask

  task automatic load_config(input logic [31:0] magic, input logic [15:0] version);
    cur_magic   = magic;
    cur_version = version;
    cfg_en    <= 1'b1;
    cfg_index <= REG_MAGIC_WORD;
    cfg_data  <= magic;
    @(posedge clk);
    cfg_index <= REG_FORMAT_VERSION;
    cfg_data  <= {16'd0, version};
    @(posedge clk);
    cfg_en <= 1'b0;
  endtask

  // Stop offering, wait until every owed outcome is in, then let the pipe drain
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    do @(negedge clk); while (outcomes_owed != 0);
    repeat (tail) @(posedge clk);
  endtask

  // One random slot: half well-formed messages, the rest broken or noise
  task automatic random_slot();
    int          pick;
    int          n;
    int          at;
    logic [31:0] seq;
    logic [31:0] prev;
    logic [15:0] len;
    bit          stray;
    pick  = $urandom_range(99);
    seq   = $urandom;
    prev  = $urandom;
    stray = 1'b0;
    if (prev == seq) prev = ~seq;
    len = ($urandom_range(9) == 0) ? 16'($urandom_range(60, 13)) :
                                     16'($urandom_range(12, 0));

    if (pick < 50) begin
      // good message, sometimes with trailing bytes
      add_message(cur_magic, cur_version, len, seq,
                  len + (($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0), 1'b0);
    end else if (pick < 60) begin
      add_message(cur_magic, cur_version, len, seq, len, 1'b1);
    end else if (pick < 67) begin
      // slot ends inside header or payload
      add_message(cur_magic, cur_version, len, seq, len, 1'b0);
      n = $urandom_range(slot_q.size() - 1, 1);
      while (slot_q.size() > n) void'(slot_q.pop_back());
    end else if (pick < 72) begin
      add_message(cur_magic, cur_version, 16'($urandom_range(65535, MAX_PAYLOAD + 1)), seq,
                  $urandom_range(8, 0), 1'b0);
    end else if (pick < 77) begin
      // repeated sequence
      prev = seq;
      add_message(cur_magic, cur_version, len, seq, len, 1'b0);
    end else if (pick < 83) begin
      if ($urandom_range(1))
        add_message(cur_magic ^ (32'd1 << $urandom_range(31)), cur_version, len, seq,
                    len, 1'b0);
      else
        add_message(cur_magic, cur_version ^ (16'd1 << $urandom_range(15)), len, seq,
                    len, 1'b0);
    end else if (pick < 90) begin
      // noise with stray start and end flags inside
      n = $urandom_range(24, 1);
      repeat (n) push_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
    end else if (pick < 95) begin
      // partial slot, then a fresh start in mid-slot
      n = $urandom_range(15, 1);
      repeat (n) push_byte(8'($urandom), 1'b0, 1'b0);
      at = slot_q.size();
      add_message(cur_magic, cur_version, len, seq, len, 1'b0);
      slot_q[at].first = 1'b1;
      slot_q[at].prev  = prev;
      prev = $urandom;
    end else begin
      // bytes outside any slot
      stray = 1'b1;
      n = $urandom_range(3, 1);
      repeat (n) push_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
    end

    if (!stray) begin
      mark_slot(prev);
      phase_items += slot_q.size();
    end
    send_slot();
  endtask

  initial begin : stimulus
    logic [31:0] seq;
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    data_byte         <= '0;
    frame_start       <= 1'b0;
    frame_end         <= 1'b0;
    previous_sequence <= '0;
    cfg_en            <= 1'b0;
    cfg_index         <= REG_MAGIC_WORD;
    cfg_data          <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    load_config(32'd0, 16'd0);

    // byte before any slot is ignored
    push_byte(8'hFF, 1'b0, 1'b1);
    send_slot();
    // one-byte slot: zero header, short, so corrupt
    push_byte(8'h00, 1'b0, 1'b0);
    mark_slot(32'hFFFF_FFFF);
    send_slot();
    // restart in mid-slot, then a short header
    push_byte(8'h11, 1'b0, 1'b0);
    push_byte(8'h22, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    slot_q[2].prev = 32'h8000_0000;
    mark_slot(32'h0000_0001);
    send_slot();
    // empty payload, all-ones sequence
    add_message(32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF, 0, 1'b0);
    mark_slot(32'd0);
    send_slot();

    for (int ph = 0; ph < 5; ph++) begin
      settle(4);
      phase_items = 0;
      case (ph)
        0: load_config($urandom, 16'($urandom));
        1: load_config(32'hFFFF_FFFF, 16'hFFFF);
        2: begin
          // long stretch with no idling on either side
          idle_on = 1'b0;
          load_config($urandom, 16'd0);
        end
        3: begin
          idle_on = 1'b1;
          load_config(32'd0, 16'($urandom));
          // receiver holds off while one-byte slots pile up
          want_hold = 1'b1;
          repeat (40) begin
            push_byte(8'($urandom), 1'b0, 1'b0);
            mark_slot($urandom);
            phase_items++;
            send_slot();
          end
        end
        default: begin
          load_config($urandom, 16'($urandom));
          // longest payload in a slot longer than the mailbox
          seq = $urandom;
          add_message(cur_magic, cur_version, 16'(MAX_PAYLOAD), seq, MAX_PAYLOAD + 20,
                      1'b0);
          mark_slot(~seq);
          send_slot();
        end
      endcase
      while (phase_items < PHASE_ITEMS) random_slot();
    end

    settle(10);
    if (mismatches == 0 && outcomes_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: mailbox_frame_validator.f
src/mfv_pkg.sv
src/mfv_frame_check.sv
src/mfv_result_queue.sv
src/mailbox_frame_validator.sv
src/mfv_checker.sv
sim/mailbox_frame_validator_chk.sv
sim/mailbox_frame_validator_tb.sv
